>>> design/ble_dt_pkg.sv
// Shared types, constants and the vendor lookup for the device table.
// Used by ble_dt_mem and ble_device_table_core; depends on nothing else.
package ble_dt_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 64;
	localparam logic [31:0] TIMEOUT_RESET = 32'd15000;

	localparam logic [1:0] REQ_ADVERT = 2'd0;
	localparam logic [1:0] REQ_AGE    = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;
	localparam logic [1:0] REQ_SNAP   = 2'd3;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_UPDATED  = 3'd1;
	localparam logic [2:0] ST_DROPPED  = 3'd2;
	localparam logic [2:0] ST_CLEARED  = 3'd3;
	localparam logic [2:0] ST_AGED     = 3'd4;
	localparam logic [2:0] ST_ENTRY    = 3'd5;
	localparam logic [2:0] ST_EMPTY    = 3'd6;

	localparam logic [15:0] CID_PHONE    = 16'h004C;
	localparam logic [7:0]  TYPE_BEACON  = 8'h02;
	localparam logic [7:0]  SUB_BEACON   = 8'h15;
	localparam logic [7:0]  TYPE_PROX    = 8'h07;
	localparam logic [7:0]  TYPE_WATCH   = 8'h09;
	localparam logic [7:0]  TYPE_NEARBY  = 8'h10;
	localparam logic [7:0]  TYPE_FIND_A  = 8'h12;
	localparam logic [7:0]  TYPE_FIND_B  = 8'h16;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [31:0]       now_ms;
		logic [47:0]       dev_addr;
		logic signed [7:0] signal_dbm;
		logic              has_name;
		logic [7:0]        mfr_len;
		logic [15:0]       company_id;
		logic [7:0]        mfr_type;
		logic [7:0]        mfr_subtype;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [6:0]        entry_count;
		logic [47:0]       out_addr;
		logic signed [7:0] out_signal;
		logic [4:0]        out_vendor;
		logic              out_named;
		logic [5:0]        out_rank;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic [47:0]       addr;
		logic signed [7:0] signal;
		logic [4:0]        vendor;
		logic              named;
		logic [31:0]       seen;
	} entry_t;

	function automatic logic [4:0] vendor_code(input logic [15:0] cid, input logic [7:0] len,
		input logic [7:0] typ, input logic [7:0] sub);
		logic [4:0] v;
		v = 5'd0;
		if (len >= 8'd2) begin
			if (cid == CID_PHONE && len >= 8'd3) begin
				if (typ == TYPE_BEACON && len >= 8'd4 && sub == SUB_BEACON) v = 5'd1;
				else if (typ == TYPE_PROX) v = 5'd2;
				else if (typ == TYPE_WATCH) v = 5'd3;
				else if (typ == TYPE_NEARBY) v = 5'd4;
				else if (typ == TYPE_FIND_A || typ == TYPE_FIND_B) v = 5'd5;
				else v = 5'd6;
			end else begin
				case (cid)
					16'h0006: v = 5'd7;
					16'h00E0: v = 5'd8;
					16'h0075: v = 5'd9;
					16'h0087: v = 5'd10;
					16'h038F: v = 5'd11;
					16'h0157: v = 5'd12;
					16'h0499: v = 5'd13;
					16'h05A7: v = 5'd14;
					16'h004F: v = 5'd15;
					16'h0059: v = 5'd16;
					16'h000D: v = 5'd17;
					16'h000F: v = 5'd18;
					16'h0001: v = 5'd19;
					16'h0002: v = 5'd20;
					16'h0046: v = 5'd21;
					16'h0131: v = 5'd22;
					16'h0118: v = 5'd23;
					16'h009E: v = 5'd24;
					16'h0171: v = 5'd25;
					default:  v = 5'd0;
				endcase
			end
		end
		return v;
	endfunction

endpackage

>>> design/ble_dt_mem.sv
// Entry memory of the device table: one write port, one registered read port.
// Depends on ble_dt_pkg for the entry type.
module ble_dt_mem #(
	parameter int unsigned DEPTH = ble_dt_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned AW = 6
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  ble_dt_pkg::entry_t wr_data,
	input  logic [AW-1:0]      rd_addr,
	output ble_dt_pkg::entry_t rd_data
);

	ble_dt_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

endmodule

>>> design/ble_device_table_core.sv
// Device table controller: request sequencing, search, age compaction and
// sorted snapshot over the entry memory. Depends on ble_dt_pkg and ble_dt_mem.
// Each entry visit is a memory read (S_RD), then a check (S_CHK); n = fill count.
// Advert and age scan the table once; clear needs no scan; snapshot: n passes
// over the table, one result per pass. One item is worked on at a time.
// Reset empties the table and sets the timeout to 15000 ms; entries need no clearing.
module ble_device_table_core #(
	parameter int unsigned TABLE_DEPTH = ble_dt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ble_dt_pkg::in_item_t  in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ble_dt_pkg::out_item_t out_item,
	input  logic                  cfg_we,
	input  logic [31:0]           cfg_data
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_WR, S_OUT} state_t;

	state_t                state_q;
	ble_dt_pkg::in_item_t  item_q;
	logic [4:0]            vend_q;
	logic [31:0]           timeout_q;
	logic [CW-1:0]         fill_q, w_q, rank_q;
	logic [AW-1:0]         i_q, idx_q, best_idx_q, last_idx_q;
	ble_dt_pkg::entry_t    ent_q, best_q;
	logic                  have_best_q, have_last_q, more_q;
	logic signed [7:0]     last_sig_q;
	logic [2:0]            wstat_q;
	ble_dt_pkg::out_item_t out_q;
	logic                  out_valid_q;

	ble_dt_pkg::entry_t d, upd, wr_data;
	logic               wr_en, age_keep, after_last, better, is_last_i;
	logic [AW-1:0]      wr_addr;
	logic [CW-1:0]      w_next;

	ble_dt_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(i_q), .rd_data(d)
	);

	function automatic ble_dt_pkg::out_item_t mk(input logic [2:0] st, input logic [CW-1:0] cnt,
		input ble_dt_pkg::entry_t e, input logic has, input logic [CW-1:0] rk,
		input logic lst);
		ble_dt_pkg::out_item_t o;
		o = '0;
		o.status = st;
		o.entry_count = 7'(cnt);
		if (has) begin
			o.out_addr = e.addr;
			o.out_signal = e.signal;
			o.out_vendor = e.vendor;
			o.out_named = e.named;
			o.out_rank = 6'(rk);
		end
		o.last = lst;
		return o;
	endfunction

	always_comb begin
		age_keep = (item_q.now_ms - d.seen) < timeout_q;
		after_last = !have_last_q || (d.signal < last_sig_q) ||
			(d.signal == last_sig_q && i_q > last_idx_q);
		better = !have_best_q || (d.signal > best_q.signal);
		is_last_i = (i_q == AW'(fill_q - CW'(1)));
		w_next = age_keep ? w_q + CW'(1) : w_q;
		upd = ent_q;
		upd.signal = item_q.signal_dbm;
		upd.seen = item_q.now_ms;
		upd.named = ent_q.named | item_q.has_name;
		if (vend_q != 5'd0) upd.vendor = vend_q;
		wr_en = (state_q == S_WR) ||
			(state_q == S_CHK && item_q.req_type == ble_dt_pkg::REQ_AGE && age_keep);
		wr_addr = (state_q == S_WR) ? idx_q : AW'(w_q);
		wr_data = (state_q == S_WR) ? upd : d;
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			timeout_q <= ble_dt_pkg::TIMEOUT_RESET;
			out_valid_q <= 1'b0;
			more_q <= 1'b0;
			have_best_q <= 1'b0;
			have_last_q <= 1'b0;
		end else begin
			if (cfg_we) timeout_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_item;
						vend_q <= ble_dt_pkg::vendor_code(in_item.company_id, in_item.mfr_len,
							in_item.mfr_type, in_item.mfr_subtype);
						i_q <= '0;
						w_q <= '0;
						rank_q <= '0;
						have_best_q <= 1'b0;
						have_last_q <= 1'b0;
						more_q <= 1'b0;
						unique case (in_item.req_type)
							ble_dt_pkg::REQ_ADVERT: begin
								if (fill_q == '0) begin
									ent_q <= '{addr: in_item.dev_addr, default: '0};
									idx_q <= '0;
									wstat_q <= ble_dt_pkg::ST_INSERTED;
									fill_q <= fill_q + CW'(1);
									state_q <= S_WR;
								end else state_q <= S_RD;
							end
							ble_dt_pkg::REQ_AGE: begin
								if (fill_q == '0) begin
									out_q <= mk(ble_dt_pkg::ST_AGED, '0, '0, 1'b0, '0, 1'b1);
									out_valid_q <= 1'b1;
									state_q <= S_OUT;
								end else state_q <= S_RD;
							end
							ble_dt_pkg::REQ_CLEAR: begin
								fill_q <= '0;
								out_q <= mk(ble_dt_pkg::ST_CLEARED, '0, '0, 1'b0, '0, 1'b1);
								out_valid_q <= 1'b1;
								state_q <= S_OUT;
							end
							ble_dt_pkg::REQ_SNAP: begin
								if (fill_q == '0) begin
									out_q <= mk(ble_dt_pkg::ST_EMPTY, '0, '0, 1'b0, '0, 1'b1);
									out_valid_q <= 1'b1;
									state_q <= S_OUT;
								end else state_q <= S_RD;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					unique case (item_q.req_type)
						ble_dt_pkg::REQ_ADVERT: begin
							if (d.addr == item_q.dev_addr) begin
								ent_q <= d;
								idx_q <= i_q;
								wstat_q <= ble_dt_pkg::ST_UPDATED;
								state_q <= S_WR;
							end else if (is_last_i) begin
								if (fill_q == CW'(TABLE_DEPTH)) begin
									out_q <= mk(ble_dt_pkg::ST_DROPPED, fill_q, '0, 1'b0, '0, 1'b1);
									out_valid_q <= 1'b1;
									state_q <= S_OUT;
								end else begin
									ent_q <= '{addr: item_q.dev_addr, default: '0};
									idx_q <= AW'(fill_q);
									wstat_q <= ble_dt_pkg::ST_INSERTED;
									fill_q <= fill_q + CW'(1);
									state_q <= S_WR;
								end
							end else begin
								i_q <= i_q + AW'(1);
								state_q <= S_RD;
							end
						end
						ble_dt_pkg::REQ_AGE: begin
							w_q <= w_next;
							if (is_last_i) begin
								fill_q <= w_next;
								out_q <= mk(ble_dt_pkg::ST_AGED, w_next, '0, 1'b0, '0, 1'b1);
								out_valid_q <= 1'b1;
								state_q <= S_OUT;
							end else begin
								i_q <= i_q + AW'(1);
								state_q <= S_RD;
							end
						end
						default: begin
							if (after_last && better) begin
								best_q <= d;
								best_idx_q <= i_q;
								have_best_q <= 1'b1;
							end
							if (is_last_i) begin
								out_q <= mk(ble_dt_pkg::ST_ENTRY, fill_q,
									(after_last && better) ? d : best_q, 1'b1, rank_q,
									rank_q == fill_q - CW'(1));
								more_q <= (rank_q != fill_q - CW'(1));
								out_valid_q <= 1'b1;
								state_q <= S_OUT;
							end else begin
								i_q <= i_q + AW'(1);
								state_q <= S_RD;
							end
						end
					endcase
				end
				S_WR: begin
					out_q <= mk(wstat_q, fill_q, '0, 1'b0, '0, 1'b1);
					out_valid_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (more_q) begin
							have_last_q <= 1'b1;
							last_sig_q <= best_q.signal;
							last_idx_q <= best_idx_q;
							have_best_q <= 1'b0;
							rank_q <= rank_q + CW'(1);
							i_q <= '0;
							state_q <= S_RD;
						end else state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> tb/ble_device_table_core_tb.sv
// Self-checking testbench for ble_device_table_core: directed table, then random traffic.
// Depends on ble_dt_pkg and the core RTL; predicts results with its own table model (typed directed rows give theirs).
module ble_device_table_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = ble_dt_pkg::TABLE_DEPTH_DEF;
	localparam int IDLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	ble_dt_pkg::in_item_t in_item;
	logic out_valid;
	logic out_stall;
	ble_dt_pkg::out_item_t out_item;
	logic cfg_we;
	logic [31:0] cfg_data;

	ble_device_table_core #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	ble_dt_pkg::entry_t tbl[DEPTH];
	int fill;
	logic [31:0] timeout_ms;
	ble_dt_pkg::out_item_t pending_q[$];
	int fail_cnt = 0;
	int result_cnt = 0;
	int item_cnt;
	int idle_cycles = 0;
	bit hold_long;

	typedef struct {
		ble_dt_pkg::in_item_t item;
		bit typed;
		ble_dt_pkg::out_item_t want;
	} dir_row_t;
	dir_row_t dir_rows[$];

	function automatic logic [4:0] lookup_vendor(ble_dt_pkg::in_item_t it);
		if (it.mfr_len < 2) return 5'd0;
		if (it.company_id == ble_dt_pkg::CID_PHONE && it.mfr_len >= 3) begin
			if (it.mfr_type == ble_dt_pkg::TYPE_BEACON && it.mfr_len >= 4 &&
				it.mfr_subtype == ble_dt_pkg::SUB_BEACON)
				return 5'd1;
			case (it.mfr_type)
				ble_dt_pkg::TYPE_PROX: return 5'd2;
				ble_dt_pkg::TYPE_WATCH: return 5'd3;
				ble_dt_pkg::TYPE_NEARBY: return 5'd4;
				ble_dt_pkg::TYPE_FIND_A, ble_dt_pkg::TYPE_FIND_B: return 5'd5;
				default: return 5'd6;
			endcase
		end
		case (it.company_id)
			16'h0006: return 5'd7;
			16'h00E0: return 5'd8;
			16'h0075: return 5'd9;
			16'h0087: return 5'd10;
			16'h038F: return 5'd11;
			16'h0157: return 5'd12;
			16'h0499: return 5'd13;
			16'h05A7: return 5'd14;
			16'h004F: return 5'd15;
			16'h0059: return 5'd16;
			16'h000D: return 5'd17;
			16'h000F: return 5'd18;
			16'h0001: return 5'd19;
			16'h0002: return 5'd20;
			16'h0046: return 5'd21;
			16'h0131: return 5'd22;
			16'h0118: return 5'd23;
			16'h009E: return 5'd24;
			16'h0171: return 5'd25;
			default: return 5'd0;
		endcase
	endfunction

	function automatic ble_dt_pkg::out_item_t plain_result(logic [2:0] st);
		ble_dt_pkg::out_item_t r;
		r = '0;
		r.status = st;
		r.entry_count = fill[6:0];
		r.last = 1'b1;
		return r;
	endfunction

	task automatic predict_table(ble_dt_pkg::in_item_t it);
		int idx;
		int w;
		int order[$];
		int j;
		logic [4:0] vend;
		ble_dt_pkg::out_item_t r;
		case (it.req_type)
			ble_dt_pkg::REQ_ADVERT: begin
				idx = -1;
				vend = lookup_vendor(it);
				for (int i = 0; i < fill; i++)
					if (idx < 0 && tbl[i].addr == it.dev_addr) idx = i;
				if (idx < 0 && fill >= DEPTH) begin
					pending_q.push_back(plain_result(ble_dt_pkg::ST_DROPPED));
				end else begin
					r.status = ble_dt_pkg::ST_UPDATED;
					if (idx < 0) begin
						idx = fill;
						fill++;
						tbl[idx].addr = it.dev_addr;
						tbl[idx].vendor = 0;
						tbl[idx].named = 0;
						r.status = ble_dt_pkg::ST_INSERTED;
					end
					tbl[idx].signal = it.signal_dbm;
					tbl[idx].seen = it.now_ms;
					if (it.has_name) tbl[idx].named = 1;
					if (vend != 0) tbl[idx].vendor = vend;
					pending_q.push_back(plain_result(r.status));
				end
			end
			ble_dt_pkg::REQ_AGE: begin
				w = 0;
				for (int i = 0; i < fill; i++)
					if (32'(it.now_ms - tbl[i].seen) < timeout_ms) begin
						tbl[w] = tbl[i];
						w++;
					end
				fill = w;
				pending_q.push_back(plain_result(ble_dt_pkg::ST_AGED));
			end
			ble_dt_pkg::REQ_CLEAR: begin
				fill = 0;
				pending_q.push_back(plain_result(ble_dt_pkg::ST_CLEARED));
			end
			default: begin
				if (fill == 0) begin
					pending_q.push_back(plain_result(ble_dt_pkg::ST_EMPTY));
				end else begin
					for (int i = 0; i < fill; i++) begin
						j = order.size();
						while (j > 0 && tbl[order[j-1]].signal < tbl[i].signal) j--;
						order.insert(j, i);
					end
					for (int i = 0; i < fill; i++) begin
						r.status = ble_dt_pkg::ST_ENTRY;
						r.entry_count = fill[6:0];
						r.out_addr = tbl[order[i]].addr;
						r.out_signal = tbl[order[i]].signal;
						r.out_vendor = tbl[order[i]].vendor;
						r.out_named = tbl[order[i]].named;
						r.out_rank = i[5:0];
						r.last = (i == fill - 1);
						pending_q.push_back(r);
					end
				end
			end
		endcase
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Receiver: stalls on its own pattern, with one long hold-off on request.
	initial begin
		int mode;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_long) out_stall <= 1'b1;
			else begin
				mode = ($time / 20000) % 3;
				if (mode == 0) out_stall <= 1'b0;
				else out_stall <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			ble_dt_pkg::out_item_t w;
			result_cnt++;
			if (pending_q.size() == 0) begin
				$error("result with no expectation: %p", out_item);
				fail_cnt++;
			end else begin
				w = pending_q.pop_front();
				if (out_item.status !== w.status) begin
					$error("status exp %0d got %0d", w.status, out_item.status); fail_cnt++;
				end
				if (out_item.entry_count !== w.entry_count) begin
					$error("entry_count exp %0d got %0d", w.entry_count, out_item.entry_count);
					fail_cnt++;
				end
				if (out_item.out_addr !== w.out_addr) begin
					$error("out_addr exp %h got %h", w.out_addr, out_item.out_addr); fail_cnt++;
				end
				if (out_item.out_signal !== w.out_signal) begin
					$error("out_signal exp %0d got %0d", w.out_signal, out_item.out_signal);
					fail_cnt++;
				end
				if (out_item.out_vendor !== w.out_vendor) begin
					$error("out_vendor exp %0d got %0d", w.out_vendor, out_item.out_vendor);
					fail_cnt++;
				end
				if (out_item.out_named !== w.out_named) begin
					$error("out_named exp %0d got %0d", w.out_named, out_item.out_named);
					fail_cnt++;
				end
				if (out_item.out_rank !== w.out_rank) begin
					$error("out_rank exp %0d got %0d", w.out_rank, out_item.out_rank); fail_cnt++;
				end
				if (out_item.last !== w.last) begin
					$error("last exp %0d got %0d", w.last, out_item.last); fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired");
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_item(ble_dt_pkg::in_item_t it);
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_table(it);
		item_cnt++;
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain_then_write(logic [31:0] val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		timeout_ms = val;
	endtask

	function automatic ble_dt_pkg::in_item_t make_item(logic [1:0] rq, logic [31:0] t,
		logic [47:0] a, logic [7:0] s, logic nm, logic [7:0] ln, logic [15:0] cid,
		logic [7:0] ty, logic [7:0] sb);
		ble_dt_pkg::in_item_t it;
		it.req_type = rq; it.now_ms = t; it.dev_addr = a; it.signal_dbm = s;
		it.has_name = nm; it.mfr_len = ln; it.company_id = cid;
		it.mfr_type = ty; it.mfr_subtype = sb;
		return it;
	endfunction

	function automatic ble_dt_pkg::in_item_t rand_item(int n_addr, logic [31:0] base);
		ble_dt_pkg::in_item_t it;
		int pick;
		it = make_item(ble_dt_pkg::REQ_ADVERT, base + $urandom_range(0, 3000),
			48'({$urandom, $urandom}), 8'($urandom), 1'($urandom), 8'($urandom),
			16'($urandom), 8'($urandom), 8'($urandom));
		if ($urandom_range(0, 3) != 0)
			it.dev_addr = 48'h5000_0000_0000 + 48'($urandom_range(0, n_addr));
		if ($urandom_range(0, 1)) it.mfr_len = 8'($urandom_range(0, 5));
		pick = $urandom_range(0, 5);
		if (pick == 0) it.company_id = ble_dt_pkg::CID_PHONE;
		else if (pick == 1) it.company_id = 16'h0006 + 16'($urandom_range(0, 2));
		if ($urandom_range(0, 2) == 0) it.mfr_type = 8'($urandom_range(0, 'h17));
		if ($urandom_range(0, 1)) it.mfr_subtype = ble_dt_pkg::SUB_BEACON;
		pick = $urandom_range(0, 19);
		if (pick < 2) it.req_type = ble_dt_pkg::REQ_AGE;
		else if (pick == 2) it.req_type = ble_dt_pkg::REQ_CLEAR;
		else if (pick < 6) it.req_type = ble_dt_pkg::REQ_SNAP;
		return it;
	endfunction

	initial begin
		dir_row_t row;
		ble_dt_pkg::out_item_t want;
		ble_dt_pkg::in_item_t it;
		arst_n = 0;
		in_valid = 0;
		in_item = '0;
		cfg_we = 0;
		cfg_data = '0;
		hold_long = 0;
		fill = 0;
		timeout_ms = ble_dt_pkg::TIMEOUT_RESET;
		item_cnt = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		want = '0; want.status = ble_dt_pkg::ST_EMPTY; want.last = 1;
		row.item = make_item(ble_dt_pkg::REQ_SNAP, 0, 0, 0, 0, 0, 0, 0, 0);
		row.typed = 1; row.want = want; dir_rows.push_back(row);
		want.status = ble_dt_pkg::ST_INSERTED; want.entry_count = 1;
		row.item = make_item(ble_dt_pkg::REQ_ADVERT, 0, 48'hFFFF_FFFF_FFFF, 8'h7F, 1, 4,
			ble_dt_pkg::CID_PHONE, ble_dt_pkg::TYPE_BEACON, ble_dt_pkg::SUB_BEACON);
		row.want = want; dir_rows.push_back(row);
		row.typed = 0;
		row.item = make_item(ble_dt_pkg::REQ_ADVERT, 32'hFFFF_FFFF, 0, 8'h80, 0, 2,
			ble_dt_pkg::CID_PHONE, 8'h07, 0);
		dir_rows.push_back(row);
		row.item = make_item(ble_dt_pkg::REQ_ADVERT, 5, 1, 8'h80, 1, 3,
			ble_dt_pkg::CID_PHONE, ble_dt_pkg::TYPE_PROX, 0);
		dir_rows.push_back(row);
		row.item = make_item(ble_dt_pkg::REQ_ADVERT, 6, 2, 8'h80, 0, 3,
			ble_dt_pkg::CID_PHONE, ble_dt_pkg::TYPE_WATCH, 0);
		dir_rows.push_back(row);
		row.item = make_item(ble_dt_pkg::REQ_ADVERT, 7, 3, 8'h10, 0, 3,
			ble_dt_pkg::CID_PHONE, ble_dt_pkg::TYPE_NEARBY, 0);
		dir_rows.push_back(row);
		row.item = make_item(ble_dt_pkg::REQ_ADVERT, 8, 4, 8'h10, 0, 3,
			ble_dt_pkg::CID_PHONE, ble_dt_pkg::TYPE_FIND_B, 0);
		dir_rows.push_back(row);
		row.item = make_item(ble_dt_pkg::REQ_ADVERT, 9, 5, 0, 0, 3,
			ble_dt_pkg::CID_PHONE, ble_dt_pkg::TYPE_BEACON, ble_dt_pkg::SUB_BEACON);
		dir_rows.push_back(row);
		row.item = make_item(ble_dt_pkg::REQ_ADVERT, 9, 6, 0, 0, 1, 16'h0171, 0, 0);
		dir_rows.push_back(row);
		row.item = make_item(ble_dt_pkg::REQ_ADVERT, 9, 7, 1, 0, 255, 16'h0171, 0, 0);
		dir_rows.push_back(row);
		row.item = make_item(ble_dt_pkg::REQ_ADVERT, 10, 1, 8'hF0, 0, 0, 0, 0, 0);
		dir_rows.push_back(row);
		row.item = make_item(ble_dt_pkg::REQ_SNAP, 10, 0, 0, 0, 0, 0, 0, 0);
		dir_rows.push_back(row);
		row.item = make_item(ble_dt_pkg::REQ_AGE, 15005, 0, 0, 0, 0, 0, 0, 0);
		dir_rows.push_back(row);
		row.item = make_item(ble_dt_pkg::REQ_SNAP, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_rows.push_back(row);
		want = '0; want.status = ble_dt_pkg::ST_CLEARED; want.last = 1;
		row.item = make_item(ble_dt_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
		row.typed = 1; row.want = want; dir_rows.push_back(row);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].typed) begin
				in_valid <= 1'b1;
				in_item <= dir_rows[k].item;
				@(posedge clk);
				while (in_stall) @(posedge clk);
				pending_q.push_back(dir_rows[k].want);
				if (dir_rows[k].item.req_type == ble_dt_pkg::REQ_ADVERT) begin
					fill++;
					tbl[0] = '{dir_rows[k].item.dev_addr, dir_rows[k].item.signal_dbm,
						5'd1, 1'b1, dir_rows[k].item.now_ms};
				end else fill = 0;
				item_cnt++;
			end else send_item(dir_rows[k].item);
		end

		// Fill the table past capacity, then look at it with the receiver held off.
		for (int i = 0; i < DEPTH + 2; i++)
			send_item(make_item(ble_dt_pkg::REQ_ADVERT, 100, 48'h7000_0000_0000 + 48'(i),
				8'($urandom), i[0], 2, 16'h0006, 0, 0));
		send_item(make_item(ble_dt_pkg::REQ_ADVERT, 101, 48'h7000_0000_0003, 8'h7F, 0, 0, 0,
			0, 0));
		hold_long = 1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_long = 0;
			end
			begin
				send_item(make_item(ble_dt_pkg::REQ_SNAP, 0, 0, 0, 0, 0, 0, 0, 0));
				send_item(make_item(ble_dt_pkg::REQ_ADVERT, 50, 48'h7000_0000_0001, 0, 1, 0,
					0, 0, 0));
				send_item(make_item(ble_dt_pkg::REQ_SNAP, 0, 0, 0, 0, 0, 0, 0, 0));
			end
		join

		drain_then_write(32'd0);
		send_item(make_item(ble_dt_pkg::REQ_AGE, 0, 0, 0, 0, 0, 0, 0, 0));
		drain_then_write(32'hFFFF_FFFF);
		for (int i = 0; i < 3; i++)
			send_item(make_item(ble_dt_pkg::REQ_ADVERT, 32'hFFFF_FF00 + 32'(i),
				48'h9 + 48'(i), 0, 0, 0, 0, 0, 0));
		send_item(make_item(ble_dt_pkg::REQ_AGE, 32'hFFFF_FF00, 0, 0, 0, 0, 0, 0, 0));
		drain_then_write(32'd1);

		for (int ph = 0; ph < 4; ph++) begin
			for (int i = 0; i < 18; i++) begin
				it = rand_item(ph == 3 ? 70 : 12, 32'd1000 * 32'(ph));
				send_item(it);
			end
			drain_then_write(ph == 2 ? 32'd1 : 32'($urandom_range(1, 4000)));
		end

		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Sent %0d items (adverts, ageing, clears, snapshots incl. a full table),",
			item_cnt);
		$display("checked %0d results across several timeout settings.", result_cnt);
		if (fail_cnt == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
